// File: rtl/brf_pkg.sv
package brf_pkg;

    // Ring geometry; DEPTH must be a power of two
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = ADDR_W + 1;

    // Field widths of the request and result
    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 11;
    localparam int USED_W  = 11;

    // Width wide enough to compare a count against an occupancy
    localparam int CMP_W = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;

    localparam logic [PTR_W-1:0] DEPTH_PTR = PTR_W'(DEPTH);

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_SKIP   = 3'd3;
    localparam logic [OP_W-1:0] OP_REWIND = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [BYTE_W-1:0]  data_in;
        logic [COUNT_W-1:0] count;
    } brf_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              ok;
        logic [USED_W-1:0] used_bytes;
    } brf_out_t;

endpackage

// File: rtl/byte_ring_fifo_core.sv
// Byte ring FIFO of brf_pkg::DEPTH entries with push, pop, peek, skip and
// rewind requests. Each request gives exactly one result carrying the byte read
// (pop or peek), an ok flag and the occupancy after the operation. The block
// takes one request per cycle while s_ready is high; a stalled result side holds
// s_ready low. The pointer update happens at acceptance; the storage is one
// synchronous RAM with a registered read, so the result waits in a stage
// register for the read data before it moves to the output register. Storage
// is not cleared at reset: reading an entry that was never written (exposed by
// rewind) returns an undefined byte.
module byte_ring_fifo_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  brf_pkg::brf_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output brf_pkg::brf_out_t m_data
);

    // Pointers with wrap bit
    logic [brf_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [brf_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;

    // Storage and its registered read port
    logic [brf_pkg::BYTE_W-1:0] mem [brf_pkg::DEPTH];
    logic [brf_pkg::BYTE_W-1:0] mem_q_reg;

    // Read stage
    logic                       p_valid_reg;
    logic                       p_ok_reg, p_ok_next;
    logic                       p_rd_reg, p_rd_next;
    logic [brf_pkg::USED_W-1:0] p_used_reg, p_used_next;

    // Output register
    logic              m_valid_reg;
    brf_pkg::brf_out_t m_data_reg;

    logic                        accept;
    logic                        p_move;
    logic [brf_pkg::PTR_W-1:0]   used;
    logic [brf_pkg::PTR_W-1:0]   room;
    logic [brf_pkg::PTR_W-1:0]   used_after;
    logic [brf_pkg::CMP_W-1:0]   cnt_ext;
    logic [brf_pkg::CMP_W-1:0]   used_ext;
    logic [brf_pkg::CMP_W-1:0]   room_ext;
    logic [brf_pkg::CMP_W-1:0]   used_after_ext;
    logic [brf_pkg::PTR_W-1:0]   step;
    logic                        mem_we;
    logic                        mem_re;
    logic [brf_pkg::ADDR_W-1:0]  rd_addr;

    // Handshake: stage advances when the output register is free or draining
    assign p_move  = p_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p_valid_reg || p_move;
    assign accept  = s_valid && s_ready;

    // Occupancy and free space before the operation
    assign used     = wr_ptr_reg - rd_ptr_reg;
    assign room     = brf_pkg::DEPTH_PTR - used;
    assign cnt_ext  = brf_pkg::CMP_W'(s_data.count);
    assign used_ext = brf_pkg::CMP_W'(used);
    assign room_ext = brf_pkg::CMP_W'(room);

    // Decode the request and compute the new pointers
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        p_ok_next   = 1'b0;
        p_rd_next   = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        rd_addr     = rd_ptr_reg[brf_pkg::ADDR_W-1:0];
        step        = '0;
        case (s_data.opcode)
            brf_pkg::OP_PUSH: begin
                if (used != brf_pkg::DEPTH_PTR) begin
                    mem_we      = 1'b1;
                    wr_ptr_next = wr_ptr_reg + brf_pkg::PTR_W'(1);
                    p_ok_next   = 1'b1;
                end
            end
            brf_pkg::OP_POP: begin
                if (used != '0) begin
                    mem_re      = 1'b1;
                    rd_ptr_next = rd_ptr_reg + brf_pkg::PTR_W'(1);
                    p_ok_next   = 1'b1;
                    p_rd_next   = 1'b1;
                end
            end
            brf_pkg::OP_PEEK: begin
                rd_addr = rd_ptr_reg[brf_pkg::ADDR_W-1:0]
                        + cnt_ext[brf_pkg::ADDR_W-1:0];
                if (cnt_ext < used_ext) begin
                    mem_re    = 1'b1;
                    p_ok_next = 1'b1;
                    p_rd_next = 1'b1;
                end
            end
            brf_pkg::OP_SKIP: begin
                // Clamp to occupancy
                if (cnt_ext <= used_ext) begin
                    step      = cnt_ext[brf_pkg::PTR_W-1:0];
                    p_ok_next = 1'b1;
                end else begin
                    step = used;
                end
                rd_ptr_next = rd_ptr_reg + step;
            end
            brf_pkg::OP_REWIND: begin
                // Clamp to free space
                if (cnt_ext <= room_ext) begin
                    step      = cnt_ext[brf_pkg::PTR_W-1:0];
                    p_ok_next = 1'b1;
                end else begin
                    step = room;
                end
                rd_ptr_next = rd_ptr_reg - step;
            end
            default: begin
            end
        endcase
    end

    // Occupancy after the operation, masked to the result field
    assign used_after     = wr_ptr_next - rd_ptr_next;
    assign used_after_ext = brf_pkg::CMP_W'(used_after);
    assign p_used_next    = used_after_ext[brf_pkg::USED_W-1:0];

    // Storage: write on push, registered read on pop or peek
    always_ff @(posedge aclk) begin
        if (accept && mem_we) begin
            mem[wr_ptr_reg[brf_pkg::ADDR_W-1:0]] <= s_data.data_in;
        end
        if (accept && mem_re) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // Pointers and read stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            p_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                rd_ptr_reg <= rd_ptr_next;
                wr_ptr_reg <= wr_ptr_next;
            end
            if (accept) begin
                p_valid_reg <= 1'b1;
            end else if (p_move) begin
                p_valid_reg <= 1'b0;
            end
        end
    end

    // Read stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            p_ok_reg   <= p_ok_next;
            p_rd_reg   <= p_rd_next;
            p_used_reg <= p_used_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_move) begin
            m_data_reg.data_out   <= p_rd_reg ? mem_q_reg : '0;
            m_data_reg.ok         <= p_ok_reg;
            m_data_reg.used_bytes <= p_used_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Occupancy never exceeds the depth
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used <= brf_pkg::DEPTH_PTR)
        else $error("occupancy beyond depth");

    // A stalled request side means a result is waiting in the read stage
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (p_valid_reg && m_valid_reg && !m_ready))
        else $error("request refused without a blocked result");

    // A successful push advances the write pointer by exactly one
    a_push_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.opcode == brf_pkg::OP_PUSH
         && used != brf_pkg::DEPTH_PTR)
        |=> wr_ptr_reg == $past(wr_ptr_reg) + brf_pkg::PTR_W'(1))
        else $error("push did not advance write pointer");

    // Pointers move only on an accepted request
    a_ptr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> ($stable(rd_ptr_reg) && $stable(wr_ptr_reg)))
        else $error("pointer moved without a request");

    // A held result stays put while the stage waits behind it
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("output register changed while stalled");

endmodule
